// ===== rtl/jam_pkg.sv =====
// Package for the joystick axis mapper: types, constants and curve/expand tables.
`timescale 1ns / 1ps
package jam_pkg;

    localparam int POT_W        = 16;
    localparam int EDGE_W       = 10;
    localparam int DUTY_W       = 8;
    localparam int OUT_W        = 12;
    localparam int CURVE_W      = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 10;
    localparam int T_W          = 8;
    localparam int N_CELLS      = T_W;

    localparam logic [EDGE_W-1:0] POT_FULL_SCALE = EDGE_W'(1023);
    localparam int                DUTY_OUT_MAX   = 4095;
    localparam logic [T_W-1:0]    T_MAX          = 8'd255;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIDIR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DB_LOW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DB_HI  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DMIN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DMAX   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE  = 3'd7;

    // curve codes
    localparam logic [CURVE_W-1:0] CURVE_LINEAR = 3'd2;
    localparam logic [CURVE_W-1:0] CURVE_E15    = 3'd3;
    localparam logic [CURVE_W-1:0] CURVE_E20    = 3'd4;
    localparam logic [CURVE_W-1:0] CURVE_E25    = 3'd5;

    typedef logic [255:0][T_W-1:0]    t_lut;
    typedef logic [255:0][OUT_W-1:0]  t_xlut;

    typedef struct packed {
        logic                valid;
        logic                fwd;
        logic                rev;
        logic                sat;
        logic [EDGE_W-1:0]   rng;
        logic [EDGE_W-1:0]   rem;
        logic [T_W-1:0]      nlo;
        logic [T_W-1:0]      quo;
    } t_cell;

    typedef struct packed {
        logic        enable;
        logic        bidir;
        logic        invert;
        logic [EDGE_W-1:0] db_low;
        logic [EDGE_W-1:0] db_high;
        logic [DUTY_W-1:0] duty_min;
        logic [DUTY_W-1:0] duty_max;
        logic [CURVE_W-1:0] curve;
    } t_cfg;

    function automatic longint unsigned isqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        longint unsigned v;
        res = 0;
        v   = x;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic t_lut make_lut(int code);
        t_lut l;
        longint unsigned v;
        longint unsigned r;
        for (int i = 0; i < 256; i++) begin
            v = longint'(i);
            case (code)
                3:       r = isqrt((v * v * v) / 255);
                4:       r = (v * v) / 255;
                5:       r = isqrt((v * v * v * v * v) / (255 * 255 * 255));
                default: r = (v * v * v) / (255 * 255);
            endcase
            l[i] = r[T_W-1:0];
        end
        return l;
    endfunction

    function automatic t_xlut make_xlut();
        t_xlut l;
        longint unsigned r;
        for (int i = 0; i < 256; i++) begin
            r = (longint'(i) * DUTY_OUT_MAX) / 255;
            l[i] = r[OUT_W-1:0];
        end
        return l;
    endfunction

    localparam t_lut  LUT_E15 = make_lut(3);
    localparam t_lut  LUT_E20 = make_lut(4);
    localparam t_lut  LUT_E25 = make_lut(5);
    localparam t_lut  LUT_E30 = make_lut(6);
    localparam t_xlut XLUT    = make_xlut();

endpackage

// ===== rtl/joystick_axis_to_pwm_mapper.sv =====
// Top level of the joystick axis to PWM duty mapper.
`timescale 1ns / 1ps
// Takes one sample per cycle whenever i_start is high (o_busy is low except in reset) and
// returns o_fwd_duty/o_rev_duty with an o_valid strobe at the end of the pipeline; the
// result cannot be stalled. The pipeline is an input stage, a row of eight division
// cells, one quotient bit each, and three shaping stages. Write configuration only
// while no sample is in flight.
module joystick_axis_to_pwm_mapper (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [jam_pkg::POT_W-1:0]       i_pot_value,
    output logic                            o_valid,
    output logic [jam_pkg::OUT_W-1:0]       o_fwd_duty,
    output logic [jam_pkg::OUT_W-1:0]       o_rev_duty,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [jam_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [jam_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import jam_pkg::*;

    t_cfg               r_cfg;
    logic               r_ready;
    t_cell              r_c0;
    t_cell              n_c0;
    t_cell              chain [N_CELLS+1];
    logic               accept;
    logic [POT_W-1:0]   delta;
    logic [EDGE_W-1:0]  rng;
    logic [17:0]        num;

    assign accept      = i_start && r_ready;
    assign o_busy      = !r_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready        <= 1'b0;
            r_cfg.enable   <= 1'b0;
            r_cfg.bidir    <= 1'b1;
            r_cfg.invert   <= 1'b0;
            r_cfg.db_low   <= EDGE_W'(307);
            r_cfg.db_high  <= EDGE_W'(717);
            r_cfg.duty_min <= DUTY_W'(20);
            r_cfg.duty_max <= DUTY_W'(100);
            r_cfg.curve    <= CURVE_LINEAR;
        end else begin
            r_ready <= 1'b1;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_ENABLE: r_cfg.enable   <= i_cfg_data[0];
                    REG_BIDIR:  r_cfg.bidir    <= i_cfg_data[0];
                    REG_INVERT: r_cfg.invert   <= i_cfg_data[0];
                    REG_DB_LOW: r_cfg.db_low   <= i_cfg_data;
                    REG_DB_HI:  r_cfg.db_high  <= i_cfg_data;
                    REG_DMIN:   r_cfg.duty_min <= i_cfg_data[DUTY_W-1:0];
                    REG_DMAX:   r_cfg.duty_max <= i_cfg_data[DUTY_W-1:0];
                    REG_CURVE:  r_cfg.curve    <= i_cfg_data[CURVE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // side selection, deflection and range; reverse test wins on overlap
    always_comb begin
        n_c0       = '0;
        n_c0.valid = accept;
        delta      = '0;
        rng        = EDGE_W'(1);
        if (r_cfg.enable) begin
            if (r_cfg.bidir && (i_pot_value < POT_W'(r_cfg.db_low))) begin
                n_c0.rev = 1'b1;
                delta    = POT_W'(r_cfg.db_low) - i_pot_value;
                rng      = r_cfg.db_low;
            end else if (i_pot_value > POT_W'(r_cfg.db_high)) begin
                n_c0.fwd = 1'b1;
                delta    = i_pot_value - POT_W'(r_cfg.db_high);
                rng      = (r_cfg.db_high >= POT_FULL_SCALE) ? EDGE_W'(1)
                                                             : POT_FULL_SCALE - r_cfg.db_high;
            end
        end
        n_c0.sat = (delta >= POT_W'(rng));
        num      = (18'(delta[EDGE_W-1:0]) << 8) - 18'(delta[EDGE_W-1:0]);
        n_c0.rng = rng;
        n_c0.rem = num[17:8];
        n_c0.nlo = num[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0.valid <= 1'b0;
        end else begin
            r_c0.valid <= n_c0.valid;
        end
        r_c0.fwd <= n_c0.fwd;
        r_c0.rev <= n_c0.rev;
        r_c0.sat <= n_c0.sat;
        r_c0.rng <= n_c0.rng;
        r_c0.rem <= n_c0.rem;
        r_c0.nlo <= n_c0.nlo;
        r_c0.quo <= n_c0.quo;
    end

    assign chain[0] = r_c0;

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        jam_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_c     (chain[g]),
            .o_c     (chain[g+1])
        );
    end

    jam_shaper u_shaper (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_c        (chain[N_CELLS]),
        .i_cfg      (r_cfg),
        .o_valid    (o_valid),
        .o_fwd_duty (o_fwd_duty),
        .o_rev_duty (o_rev_duty)
    );
endmodule

// ===== rtl/jam_cell.sv =====
// One restoring-division cell: produces one quotient bit per stage.
`timescale 1ns / 1ps
module jam_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  jam_pkg::t_cell i_c,
    output jam_pkg::t_cell o_c
);
    import jam_pkg::*;

    t_cell             r_c;
    t_cell             n_c;
    logic [EDGE_W:0]   trial;
    logic              ge;

    always_comb begin
        trial = {i_c.rem, i_c.nlo[T_W-1]};
        ge    = (trial >= {1'b0, i_c.rng});
        n_c   = i_c;
        n_c.rem = ge ? EDGE_W'(trial - {1'b0, i_c.rng}) : trial[EDGE_W-1:0];
        n_c.nlo = {i_c.nlo[T_W-2:0], 1'b0};
        n_c.quo = {i_c.quo[T_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c.valid <= 1'b0;
        end else begin
            r_c.valid <= n_c.valid;
        end
        r_c.fwd <= n_c.fwd;
        r_c.rev <= n_c.rev;
        r_c.sat <= n_c.sat;
        r_c.rng <= n_c.rng;
        r_c.rem <= n_c.rem;
        r_c.nlo <= n_c.nlo;
        r_c.quo <= n_c.quo;
    end

    assign o_c = r_c;
endmodule

// ===== rtl/jam_shaper.sv =====
// Curve lookup, duty span scaling and 12-bit expansion, three register stages.
`timescale 1ns / 1ps
module jam_shaper (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  jam_pkg::t_cell             i_c,
    input  jam_pkg::t_cfg              i_cfg,
    output logic                       o_valid,
    output logic [jam_pkg::OUT_W-1:0]  o_fwd_duty,
    output logic [jam_pkg::OUT_W-1:0]  o_rev_duty
);
    import jam_pkg::*;

    logic [T_W-1:0]      t_lin;
    logic [T_W-1:0]      n_t;
    logic [DUTY_W-1:0]   span;
    logic [24:0]         scaled;
    logic [DUTY_W-1:0]   pwm;
    logic [OUT_W-1:0]    duty;

    logic                r_v1, r_v2, r_v3;
    logic                r_f1, r_f2, r_r1, r_r2;
    logic [T_W-1:0]      r_t;
    logic [15:0]         r_prod;
    logic [OUT_W-1:0]    r_fwd, r_rev;

    always_comb begin
        t_lin = i_c.sat ? T_MAX : i_c.quo;
        if (i_cfg.curve <= CURVE_LINEAR) begin
            n_t = t_lin;
        end else if (i_cfg.curve == CURVE_E15) begin
            n_t = LUT_E15[t_lin];
        end else if (i_cfg.curve == CURVE_E20) begin
            n_t = LUT_E20[t_lin];
        end else if (i_cfg.curve == CURVE_E25) begin
            n_t = LUT_E25[t_lin];
        end else begin
            n_t = LUT_E30[t_lin];
        end
        span = (i_cfg.duty_max >= i_cfg.duty_min) ? (i_cfg.duty_max - i_cfg.duty_min) : '0;
        // floor(x/255) == ((x+1)*257) >> 16 for x below 65535
        scaled = (25'(r_prod) + 25'd1) * 25'd257;
        pwm    = i_cfg.duty_min + scaled[23:16];
        duty   = XLUT[pwm];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_c.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_f1   <= i_c.fwd;
        r_r1   <= i_c.rev;
        r_t    <= n_t;
        r_f2   <= r_f1;
        r_r2   <= r_r1;
        r_prod <= span * r_t;
        r_fwd  <= r_f2 ? duty : '0;
        r_rev  <= r_r2 ? duty : '0;
    end

    assign o_valid    = r_v3;
    assign o_fwd_duty = i_cfg.invert ? r_rev : r_fwd;
    assign o_rev_duty = i_cfg.invert ? r_fwd : r_rev;
endmodule

// ===== rtl/jam_checker.sv =====
// Port-level checker for the joystick axis mapper, bound to the top level.
`timescale 1ns / 1ps
module jam_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_start,
    input logic                        o_busy,
    input logic                        o_valid,
    input logic [jam_pkg::OUT_W-1:0]   o_fwd_duty,
    input logic [jam_pkg::OUT_W-1:0]   o_rev_duty
);
    import jam_pkg::*;

    // every transaction gives exactly one result, at the end of the pipeline
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##12 o_valid)
        else $error("missing result");

    a_no_stray_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, 12))
        else $error("result without transaction");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_fwd_duty == '0 || o_rev_duty == '0))
        else $error("both sides driven");
endmodule

bind joystick_axis_to_pwm_mapper jam_checker u_jam_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_start    (i_start),
    .o_busy     (o_busy),
    .o_valid    (o_valid),
    .o_fwd_duty (o_fwd_duty),
    .o_rev_duty (o_rev_duty)
);
